@@ rtl/core/smi_pkg.sv @@
// Shared types and constants for the store mirror inserter.
// No dependencies; imported by every module of the block.
package smi_pkg;

    // Absolute store opcodes that are watched
    localparam logic [7:0] OP_STA_ABS  = 8'h8d;
    localparam logic [7:0] OP_STA_ABSX = 8'h9d;
    localparam logic [7:0] OP_STA_ABSY = 8'h99;
    localparam logic [7:0] OP_STX_ABS  = 8'h8e;
    localparam logic [7:0] OP_STY_ABS  = 8'h8c;

    // Configuration register indexes
    localparam logic [1:0] CFG_MIRROR_BASE   = 2'd0;
    localparam logic [1:0] CFG_REGISTER_PAGE = 2'd1;
    localparam logic [1:0] CFG_REGISTER_SPAN = 2'd2;

    // Configuration reset values
    localparam logic [15:0] MIRROR_BASE_RST   = 16'hc000;
    localparam logic [7:0]  REGISTER_PAGE_RST = 8'hd4;
    localparam logic [8:0]  REGISTER_SPAN_RST = 9'h020;

    // Bytes in one command and in the inserted store
    localparam int unsigned CMD_BYTES = 6;
    localparam logic [2:0]  INS_LEN   = 3'd3;
    localparam logic [2:0]  CMD_FULL  = 3'd6;

    typedef logic [CMD_BYTES-1:0][7:0] t_cmd_bytes;

    // One command: the output bytes caused by one input byte
    typedef struct packed {
        t_cmd_bytes bytes;  // bytes in emit order, index 0 first
        logic [2:0] cnt;    // number of valid bytes, 1 to 6
        logic       ins;    // first three bytes are an inserted store
        logic       last;   // final byte closes the stream
    } t_cmd;

    function automatic logic is_store_opcode(input logic [7:0] op);
        case (op)
            OP_STA_ABS, OP_STA_ABSX, OP_STA_ABSY, OP_STX_ABS, OP_STY_ABS:
                is_store_opcode = 1'b1;
            default:
                is_store_opcode = 1'b0;
        endcase
    endfunction

endpackage

@@ rtl/core/smi_front.sv @@
// Front end: holds the configuration and the three-byte window, classifies
// each input byte and builds one output command. Depends on smi_pkg.
module smi_front import smi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // input byte stream
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    // command toward the queue
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic [15:0] r_mirror_base;
    logic [7:0]  r_register_page;
    logic [8:0]  r_register_span;

    logic [7:0]  r_older, n_older;
    logic [7:0]  r_newer, n_newer;
    logic [1:0]  r_fill, n_fill;

    logic        match;
    logic [15:0] target;
    t_cmd        cmd;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirror_base   <= MIRROR_BASE_RST;
            r_register_page <= REGISTER_PAGE_RST;
            r_register_span <= REGISTER_SPAN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MIRROR_BASE:   r_mirror_base   <= i_cfg_data;
                CFG_REGISTER_PAGE: r_register_page <= i_cfg_data[7:0];
                CFG_REGISTER_SPAN: r_register_span <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Classify the candidate instruction
    assign match  = (r_fill == 2'd2) && is_store_opcode(r_older)
                    && ({1'b0, r_newer} < r_register_span)
                    && (i_byte == r_register_page);
    assign target = r_mirror_base + {8'd0, r_newer};

    // Build the command and the next window
    always_comb begin
        n_older   = r_older;
        n_newer   = r_newer;
        n_fill    = r_fill;
        cmd.bytes = '0;
        cmd.cnt   = 3'd0;
        cmd.ins   = 1'b0;
        cmd.last  = i_last;
        if (r_fill == 2'd2) begin
            if (match) begin
                cmd.bytes = {i_byte, r_newer, r_older, target[15:8], target[7:0], r_older};
                cmd.cnt   = CMD_FULL;
                cmd.ins   = 1'b1;
                n_fill    = 2'd0;
            end else begin
                cmd.bytes[0] = r_older;
                cmd.cnt      = 3'd1;
                n_older      = r_newer;
                n_newer      = i_byte;
                if (i_last) begin
                    cmd.bytes[1] = r_newer;
                    cmd.bytes[2] = i_byte;
                    cmd.cnt      = 3'd3;
                    n_fill       = 2'd0;
                end
            end
        end else if (r_fill == 2'd1) begin
            n_newer = i_byte;
            n_fill  = 2'd2;
            if (i_last) begin
                cmd.bytes[0] = r_older;
                cmd.bytes[1] = i_byte;
                cmd.cnt      = 3'd2;
                n_fill       = 2'd0;
            end
        end else begin
            n_older = i_byte;
            n_fill  = 2'd1;
            if (i_last) begin
                cmd.bytes[0] = i_byte;
                cmd.cnt      = 3'd1;
                n_fill       = 2'd0;
            end
        end
    end

    // Advance the window on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 2'd0;
        end else if (i_accept) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_older <= n_older;
            r_newer <= n_newer;
        end
    end

    // Bytes that only fill the window cause no command
    assign o_push = i_accept && (cmd.cnt != 3'd0);
    assign o_cmd  = cmd;

endmodule

@@ rtl/core/smi_queue.sv @@
// Short command queue between the front and back ends.
// Depends on smi_pkg for the command type.
module smi_queue import smi_pkg::*; #(
    parameter int unsigned DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_ready = (r_count != FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/smi_back.sv @@
// Back end: walks the head command byte by byte into the output register.
// Depends on smi_pkg for the command type and insert length.
module smi_back import smi_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    output logic       o_is_inserted
);

    logic [2:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_ins;

    logic       load;
    logic       at_end;

    assign load   = i_cmd_valid && (!r_valid || i_out_ready);
    assign at_end = (r_idx == i_cmd.cnt - 3'd1);
    assign o_pop  = load && at_end;

    // Step through the head command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx <= at_end ? 3'd0 : r_idx + 3'd1;
            end
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_cmd.bytes[r_idx];
            r_last <= i_cmd.last && at_end;
            r_ins  <= i_cmd.ins && (r_idx < INS_LEN);
        end
    end

    assign o_out_valid   = r_valid;
    assign o_out_byte    = r_byte;
    assign o_out_last    = r_last;
    assign o_is_inserted = r_ins;

endmodule

@@ rtl/core/store_instruction_mirror_inserter.sv @@
// Top level of the store mirror inserter: front end, command queue, back end.
// Depends on smi_pkg, smi_front, smi_queue and smi_back.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+--------------------------------
//   in      | input     | i_in_valid / o_in_ready    | i_in_byte, i_in_last
//   out     | output    | o_out_valid / i_out_ready  | o_out_byte, o_out_last,
//           |           |                            | o_is_inserted
//   cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// An accepted input byte is classified at its accepting edge, and any command it
// makes is queued there; the back end then sends the head command from the output
// register, one byte per cycle while i_out_ready holds. A matched store yields six
// output bytes through the single output port. The queue of QUEUE_DEPTH commands
// lets input continue while the back end drains; a full queue stalls input, even
// in a cycle that pops. Reset is synchronous and empties the window, the queue
// and the output register; cfg is always ready.
module store_instruction_mirror_inserter import smi_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    output logic        o_is_inserted,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic in_accept;
    logic push;
    t_cmd push_cmd;
    logic q_valid;
    t_cmd head_cmd;
    logic pop;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && o_in_ready;

    smi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (in_accept),
        .i_byte      (i_in_byte),
        .i_last      (i_in_last),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    smi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_ready (o_in_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    smi_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (q_valid),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_out_last    (o_out_last),
        .o_is_inserted (o_is_inserted)
    );

    // A queued command always carries at least one and at most six bytes
    a_head_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid |-> (head_cmd.cnt != 3'd0) && (head_cmd.cnt <= CMD_FULL))
        else $error("queued command has a bad byte count");

    // An inserted store always travels with its original instruction
    a_ins_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid && head_cmd.ins |-> head_cmd.cnt == CMD_FULL)
        else $error("insert command is not six bytes long");

    // The end of a stream is never an inserted byte
    a_last_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_last |-> !o_is_inserted)
        else $error("stream ends inside an inserted store");

    // Only a pushed command can make the queue non-empty
    a_push_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !q_valid && !push |=> !q_valid)
        else $error("queue filled without a push");

endmodule

@@ bench/smi_checker.sv @@
// Scoreboard for the store mirror inserter: rebuilds the patched byte stream
// from accepted input and register-write transactions and checks every output.
// Depends on smi_pkg for opcodes, register indexes and reset values.
`timescale 1ns / 100ps

module smi_checker import smi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_out_byte,
    input  logic        i_out_last,
    input  logic        i_is_inserted,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       ins;
    } t_patched_beat;

    // Bytes of the patched stream still owed by the block, oldest first
    t_patched_beat patched_q[$];

    // Register copies
    logic [15:0] mirror_base;
    logic [7:0]  watch_page;
    logic [8:0]  watch_span;

    // Three-byte scan window: two held bytes plus the incoming one
    logic [7:0]  win_old;
    logic [7:0]  win_new;
    logic [1:0]  win_fill;

    int          mismatches = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic t_patched_beat beat(input logic [7:0] data, input logic ins);
        t_patched_beat b;
        b.data = data;
        b.last = 1'b0;
        b.ins  = ins;
        return b;
    endfunction

    // Advance the window by one input byte and queue the bytes it releases
    task automatic patch_step(input logic [7:0] b, input logic last);
        t_patched_beat beats[$];
        logic [15:0]   target;
        logic          store_op;
        store_op = (win_old == OP_STA_ABS) || (win_old == OP_STA_ABSX) ||
                   (win_old == OP_STA_ABSY) || (win_old == OP_STX_ABS) ||
                   (win_old == OP_STY_ABS);
        target = mirror_base + {8'h00, win_new};
        if (win_fill == 2'd2) begin
            if (store_op && ({1'b0, win_new} < watch_span) && (b == watch_page)) begin
                // mirror store first, then the original instruction
                beats.push_back(beat(win_old, 1'b1));
                beats.push_back(beat(target[7:0], 1'b1));
                beats.push_back(beat(target[15:8], 1'b1));
                beats.push_back(beat(win_old, 1'b0));
                beats.push_back(beat(win_new, 1'b0));
                beats.push_back(beat(b, 1'b0));
                win_fill = 2'd0;
            end else begin
                // miss: release the oldest byte and slide by one
                beats.push_back(beat(win_old, 1'b0));
                win_old = win_new;
                win_new = b;
            end
        end else if (win_fill == 2'd1) begin
            win_new  = b;
            win_fill = 2'd2;
        end else begin
            win_old  = b;
            win_fill = 2'd1;
        end
        // flush whatever is held at the end of a stream
        if (last) begin
            if (win_fill >= 2'd1) beats.push_back(beat(win_old, 1'b0));
            if (win_fill == 2'd2) beats.push_back(beat(win_new, 1'b0));
            win_fill = 2'd0;
            if (beats.size() != 0) beats[beats.size() - 1].last = 1'b1;
        end
        foreach (beats[k]) patched_q.push_back(beats[k]);
    endtask

    // Outputs are handled before inputs: a byte accepted at this edge
    // cannot leave the block at the same edge
    always @(posedge i_clk) begin
        t_patched_beat want;
        if (!i_rst_n) begin
            patched_q.delete();
            mirror_base = MIRROR_BASE_RST;
            watch_page  = REGISTER_PAGE_RST;
            watch_span  = REGISTER_SPAN_RST;
            win_old     = 8'h00;
            win_new     = 8'h00;
            win_fill    = 2'd0;
        end else begin
            // compare an output transaction with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (patched_q.size() == 0) begin
                    report_mismatch($sformatf("byte %02h with nothing expected", i_out_byte));
                end else begin
                    want = patched_q.pop_front();
                    if (i_out_byte !== want.data)
                        report_mismatch($sformatf("out_byte %02h, want %02h",
                                                  i_out_byte, want.data));
                    if (i_out_last !== want.last)
                        report_mismatch($sformatf("out_last %b, want %b on byte %02h",
                                                  i_out_last, want.last, want.data));
                    if (i_is_inserted !== want.ins)
                        report_mismatch($sformatf("is_inserted %b, want %b on byte %02h",
                                                  i_is_inserted, want.ins, want.data));
                end
            end
            // track register writes; unknown indexes are dropped
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MIRROR_BASE:   mirror_base = i_cfg_data;
                    CFG_REGISTER_PAGE: watch_page  = i_cfg_data[7:0];
                    CFG_REGISTER_SPAN: watch_span  = i_cfg_data[8:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) patch_step(i_in_byte, i_in_last);
        end
        o_pending = patched_q.size();
        o_errors  = mismatches;
    end

endmodule

@@ bench/tb_top.sv @@
// Top of the store mirror inserter bench: clock, reset, stimulus and verdict.
// Depends on smi_pkg, store_instruction_mirror_inserter and smi_checker.
`timescale 1ns / 100ps

module tb_top;
    import smi_pkg::*;

    localparam int         CLK_PERIOD     = 4;
    localparam int         SETTLE_CYCLES  = 10;
    localparam int         CYCLE_LIMIT    = 200000;
    localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_in_byte   = 8'h00;
    logic        i_in_last   = 1'b0;
    logic        i_out_ready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [15:0] i_cfg_data  = 16'h0000;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_out_byte;
    logic        o_out_last;
    logic        o_is_inserted;
    logic        o_cfg_ready;

    int          errors;
    int          pending;

    // Sender pacing and the register values the stimulus aims at
    int          burst_left   = 0;
    bit          gappy        = 1'b1;
    logic [7:0]  page_now;
    int          span_now;

    // Receiver pacing
    int          hold_request = 0;
    int          hold_left    = 0;
    int          pat_pos      = 0;
    logic [15:0] ready_pat    = 16'hffff;
    int          cycles       = 0;

    store_instruction_mirror_inserter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_byte     (i_in_byte),
        .i_in_last     (i_in_last),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_out_last    (o_out_last),
        .o_is_inserted (o_is_inserted),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    smi_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_in_byte     (i_in_byte),
        .i_in_last     (i_in_last),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_out_byte    (o_out_byte),
        .i_out_last    (o_out_last),
        .i_is_inserted (o_is_inserted),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: a long hold-off on request, otherwise a rotating ready pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ready_pat[pat_pos];
                pat_pos++;
                if (pat_pos == 16) begin
                    pat_pos = 0;
                    case ($urandom_range(0, 3))
                        0:       ready_pat = 16'hffff;
                        1:       ready_pat = 16'($urandom | $urandom);
                        2:       ready_pat = 16'($urandom);
                        default: ready_pat = 16'($urandom & $urandom);
                    endcase
                end
            end
        end
    end

    // Offer one byte; gaps fall only between bursts
    task automatic offer(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = gappy ? int'($urandom_range(0, 6)) : 0;
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = int'($urandom_range(1, 12));
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        i_in_last  <= last;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Hold off until every predicted byte is out, then let the block settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_config(input logic [15:0] base, input logic [15:0] page,
                              input logic [15:0] span, input logic poke_unused);
        write_reg(CFG_MIRROR_BASE, base);
        write_reg(CFG_REGISTER_PAGE, page);
        write_reg(CFG_REGISTER_SPAN, span);
        if (poke_unused) write_reg(CFG_UNUSED_IDX, 16'($urandom));
        i_cfg_valid <= 1'b0;
        page_now = page[7:0];
        span_now = int'(span[8:0]);
    endtask

    function automatic logic [7:0] pick_store_op();
        case ($urandom_range(0, 4))
            0:       return OP_STA_ABS;
            1:       return OP_STA_ABSX;
            2:       return OP_STA_ABSY;
            3:       return OP_STX_ABS;
            default: return OP_STY_ABS;
        endcase
    endfunction

    // Mostly well-formed watched stores, some near misses, some noise;
    // close with a final byte so the window is empty afterwards
    task automatic random_stream(input int count);
        int         made;
        logic [7:0] op;
        logic [7:0] lo;
        logic [7:0] hi;
        logic       cut;
        made = 0;
        while (made < count) begin
            op = pick_store_op();
            hi = page_now;
            if (span_now == 0 || span_now > 256) lo = 8'($urandom);
            else lo = 8'($urandom_range(0, span_now - 1));
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    offer(op, 1'b0);
                    offer(lo, 1'b0);
                    offer(hi, $urandom_range(0, 9) == 0);
                    made += 3;
                end
                6, 7: begin
                    // break one part of the store
                    cut = 1'b0;
                    case ($urandom_range(0, 3))
                        0:       op = op ^ (8'h01 << $urandom_range(0, 7));
                        1:       hi = hi ^ (8'h01 << $urandom_range(0, 7));
                        2:       lo = (span_now < 256) ? 8'($urandom_range(span_now, 255))
                                                       : 8'($urandom);
                        default: cut = 1'b1;
                    endcase
                    offer(op, 1'b0);
                    offer(lo, cut);
                    if (!cut) offer(hi, 1'b0);
                    made += cut ? 2 : 3;
                end
                default: begin
                    offer(8'($urandom), $urandom_range(0, 15) == 0);
                    made++;
                end
            endcase
        end
        offer(8'($urandom), 1'b1);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        page_now = REGISTER_PAGE_RST;
        span_now = int'(REGISTER_SPAN_RST);

        // Reset settings: matches at both ends of the span
        offer(OP_STA_ABS, 1'b0);
        offer(8'h00, 1'b0);
        offer(page_now, 1'b0);
        offer(OP_STA_ABSX, 1'b0);
        offer(8'(span_now - 1), 1'b0);
        offer(page_now, 1'b0);
        // low byte equal to the span misses, then a match after sliding
        offer(OP_STA_ABSY, 1'b0);
        offer(8'(span_now), 1'b0);
        offer(page_now, 1'b0);
        offer(OP_STX_ABS, 1'b0);
        offer(8'h05, 1'b0);
        offer(page_now, 1'b0);
        // wrong page, then a store cut off by the end of the stream
        offer(OP_STY_ABS, 1'b0);
        offer(8'h10, 1'b0);
        offer(page_now ^ 8'h01, 1'b0);
        offer(OP_STA_ABS, 1'b0);
        offer(8'h03, 1'b1);
        // match closing a stream, then a one-byte stream
        offer(OP_STY_ABS, 1'b0);
        offer(8'h1e, 1'b0);
        offer(page_now, 1'b1);
        offer(8'hff, 1'b1);
        wait_idle();

        // Random registers, extra bits in the page write, unknown index
        set_config(16'($urandom), 16'($urandom), 16'($urandom_range(1, 64)), 1'b1);
        random_stream(25);
        wait_idle();

        // Top extremes: span above 256 accepts every low byte, mirror wraps
        set_config(16'hffff, 16'h00ff, 16'hffff, 1'b0);
        offer(OP_STA_ABSY, 1'b0);
        offer(8'hff, 1'b0);
        offer(8'hff, 1'b0);
        random_stream(20);
        wait_idle();

        // Bottom extremes: zero span matches nothing; sender runs flat out
        gappy = 1'b0;
        set_config(16'h0000, 16'h0000, 16'h0000, 1'b1);
        random_stream(15);
        wait_idle();

        // Full-page span with a long receiver hold-off to back up the input
        set_config(16'($urandom), 16'($urandom_range(0, 255)), 16'h0100, 1'b0);
        hold_request = 150;
        random_stream(30);
        wait_idle();

        // Single watched register
        gappy = 1'b1;
        set_config(16'h8000, 16'($urandom_range(0, 255)), 16'h0001, 1'b0);
        random_stream(10);
        wait_idle();

        if (errors == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/smi_pkg.sv
rtl/core/smi_front.sv
rtl/core/smi_queue.sv
rtl/core/smi_back.sv
rtl/core/store_instruction_mirror_inserter.sv
bench/smi_checker.sv
bench/tb_top.sv
